[rtl/core/fedt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fedt_pkg;

   localparam int MAX_KEYS   = 64;
   localparam int KEY_WIDTH  = 64;
   localparam int KEY_PORT_W = 64;
   localparam int MODE_W     = 3;
   localparam int OCC_W      = 7;
   localparam int DROP_W     = 32;
   localparam int CNT_W      = $clog2(MAX_KEYS + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_CLAIM   = 3'd0,
      MODE_MARK    = 3'd1,
      MODE_RELEASE = 3'd2,
      MODE_QUERY   = 3'd3,
      MODE_CLEAR   = 3'd4
   } mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

[rtl/core/fifo_evicting_dedup_table_unit.sv]
// channel   direction  handshake              payload
// req_      in         req_valid / req_ready   mode, key, empty_key
// rsp_      out        rsp_valid / rsp_ready   claimed, present, released, evicted,
//                                              first_eviction, occupancy, dropped_total
//
// A transaction is accepted in ST_IDLE, which compares the key against all
// 64 cells at once; ST_UPDATE then updates the cells and loads the result register.
// A new transaction is taken while the previous result waits; its update cycle
// stalls until the result register is free.
// Synchronous reset empties the table and counters at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module fifo_evicting_dedup_table_unit (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire [fedt_pkg::MODE_W-1:0]      req_mode,
   input  wire [fedt_pkg::KEY_PORT_W-1:0]  req_key,
   input  wire                             req_empty_key,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic                            rsp_claimed,
   output logic                            rsp_present,
   output logic                            rsp_released,
   output logic                            rsp_evicted,
   output logic                            rsp_first_eviction,
   output logic [fedt_pkg::OCC_W-1:0]      rsp_occupancy,
   output logic [fedt_pkg::DROP_W-1:0]     rsp_dropped_total
);
   import fedt_pkg::*;

   ctrl_cmd_type cmd;

   fedt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   fedt_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_mode           (req_mode),
      .req_key            (req_key),
      .req_empty_key      (req_empty_key),
      .rsp_claimed        (rsp_claimed),
      .rsp_present        (rsp_present),
      .rsp_released       (rsp_released),
      .rsp_evicted        (rsp_evicted),
      .rsp_first_eviction (rsp_first_eviction),
      .rsp_occupancy      (rsp_occupancy),
      .rsp_dropped_total  (rsp_dropped_total)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("transaction accepted during update");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_occupancy) <= MAX_KEYS))
      else $error("occupancy above table size");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> (int'(rsp_occupancy) == MAX_KEYS) && rsp_claimed)
      else $error("eviction without full table");

   a_first_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_first_eviction |-> rsp_evicted)
      else $error("first eviction flag without eviction");

endmodule

`default_nettype wire

[rtl/core/fedt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module fedt_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output fedt_pkg::ctrl_cmd_type cmd
);
   import fedt_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // result slot must be free before the table is touched
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[rtl/core/fedt_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module fedt_datapath (
   input  wire                               clock,
   input  wire                               reset,
   input  fedt_pkg::ctrl_cmd_type            cmd,
   input  wire [fedt_pkg::MODE_W-1:0]        req_mode,
   input  wire [fedt_pkg::KEY_PORT_W-1:0]    req_key,
   input  wire                               req_empty_key,
   output logic                              rsp_claimed,
   output logic                              rsp_present,
   output logic                              rsp_released,
   output logic                              rsp_evicted,
   output logic                              rsp_first_eviction,
   output logic [fedt_pkg::OCC_W-1:0]        rsp_occupancy,
   output logic [fedt_pkg::DROP_W-1:0]       rsp_dropped_total
);
   import fedt_pkg::*;

   logic [KEY_WIDTH-1:0] key_ff [MAX_KEYS];
   logic [KEY_WIDTH-1:0] key_s  [MAX_KEYS];
   logic [KEY_WIDTH-1:0] key_in [MAX_KEYS];
   logic [MAX_KEYS-1:0]  valid_ff, valid_in, valid_s;
   logic [MAX_KEYS-1:0]  shown_ff, shown_in, shown_s;
   logic [MAX_KEYS-1:0]  match_ff, match_in;
   logic [CNT_W-1:0]     live_ff, live_in;
   logic [DROP_W-1:0]    dropped_ff, dropped_in;
   logic                 reported_ff, reported_in;

   logic [MODE_W-1:0]    mode_ff;
   logic [KEY_WIDTH-1:0] key_q_ff;
   logic                 empty_ff;

   logic [MAX_KEYS-1:0]  ge_mask, shift_mask, ins_pos;
   logic                 hit, hit_shown, full, nonempty_op;
   logic                 is_claim, is_mark, is_release, is_query, is_clear;
   logic                 do_claim, do_release, evict;

   // parallel compare of the incoming key against every live cell
   always_comb begin
      for (int i = 0; i < MAX_KEYS; i++) begin
         match_in[i] = valid_ff[i] && (key_ff[i] == req_key[KEY_WIDTH-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         match_ff <= match_in;
         mode_ff  <= req_mode;
         key_q_ff <= req_key[KEY_WIDTH-1:0];
         empty_ff <= req_empty_key;
      end
   end

   always_comb begin
      is_claim    = (mode_ff == MODE_CLAIM);
      is_mark     = (mode_ff == MODE_MARK);
      is_release  = (mode_ff == MODE_RELEASE);
      is_query    = (mode_ff == MODE_QUERY);
      is_clear    = (mode_ff == MODE_CLEAR);
      nonempty_op = !empty_ff;
      hit         = |match_ff;
      hit_shown   = |(match_ff & shown_ff);
      full        = valid_ff[MAX_KEYS-1];
      do_claim    = (is_claim || is_mark) && nonempty_op && !hit;
      evict       = do_claim && full;
      do_release  = is_release && nonempty_op && hit && !hit_shown;

      // slots at or above the matching one
      ge_mask = match_ff;
      for (int s = 1; s < MAX_KEYS; s = s * 2) begin
         ge_mask = ge_mask | (ge_mask << s);
      end

      if (evict) begin
         shift_mask = '1;
      end else if (do_release) begin
         shift_mask = ge_mask;
      end else begin
         shift_mask = '0;
      end

      valid_s = do_release ? (valid_ff >> 1) : valid_ff;

      if (!do_claim) begin
         ins_pos = '0;
      end else if (full) begin
         ins_pos = {1'b1, {(MAX_KEYS-1){1'b0}}} ;
      end else begin
         ins_pos = ~valid_ff & ((valid_ff << 1) | MAX_KEYS'(1));
      end
   end

   genvar g;
   generate
      for (g = 0; g < MAX_KEYS; g++) begin : g_cell
         if (g < MAX_KEYS - 1) begin : g_mid
            assign key_s[g]   = shift_mask[g] ? key_ff[g+1] : key_ff[g];
            assign shown_s[g] = shift_mask[g] ? shown_ff[g+1] : shown_ff[g];
         end else begin : g_top
            assign key_s[g]   = key_ff[g];
            assign shown_s[g] = shift_mask[g] ? 1'b0 : shown_ff[g];
         end
         assign key_in[g] = ins_pos[g] ? key_q_ff : key_s[g];

         always_ff @(posedge clock) begin
            if (cmd.commit) begin
               key_ff[g] <= key_in[g];
            end
         end
      end
   endgenerate

   always_comb begin
      valid_in    = valid_s | ins_pos;
      shown_in    = (shown_s & ~ins_pos) | (ins_pos & {MAX_KEYS{is_mark}});
      if (is_mark && nonempty_op && hit) begin
         shown_in = shown_in | match_ff;
      end
      live_in     = live_ff;
      dropped_in  = dropped_ff;
      reported_in = reported_ff;
      if (do_claim && !full) begin
         live_in = live_ff + CNT_W'(1);
      end
      if (do_release) begin
         live_in = live_ff - CNT_W'(1);
      end
      if (evict) begin
         reported_in = 1'b1;
         if (dropped_ff != '1) begin
            dropped_in = dropped_ff + DROP_W'(1);
         end
      end
      if (is_clear) begin
         valid_in    = '0;
         shown_in    = '0;
         live_in     = '0;
         dropped_in  = '0;
         reported_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         shown_ff    <= '0;
         live_ff     <= '0;
         dropped_ff  <= '0;
         reported_ff <= 1'b0;
      end else if (cmd.commit) begin
         valid_ff    <= valid_in;
         shown_ff    <= shown_in;
         live_ff     <= live_in;
         dropped_ff  <= dropped_in;
         reported_ff <= reported_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_claimed        <= (is_claim && (empty_ff || !hit)) || (is_mark && do_claim);
         rsp_present        <= is_query && nonempty_op && hit;
         rsp_released       <= do_release;
         rsp_evicted        <= evict;
         rsp_first_eviction <= evict && !reported_ff;
         rsp_occupancy      <= OCC_W'(live_in);
         rsp_dropped_total  <= dropped_in;
      end
   end

endmodule

`default_nettype wire
